### hdl/swm_pkg.sv
// Shared types and constants for the sliding-window median pose selector.
// Used by swm_rank and sliding_window_median_pose; depends on nothing else.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int CFG_W      = 5;
  localparam int DATA_W     = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] trans_x;
    logic signed [DATA_W-1:0] trans_y;
    logic signed [DATA_W-1:0] trans_z;
    logic signed [DATA_W-1:0] rot_x;
    logic signed [DATA_W-1:0] rot_y;
    logic signed [DATA_W-1:0] rot_z;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] med_trans_x;
    logic signed [DATA_W-1:0] med_trans_y;
    logic signed [DATA_W-1:0] med_trans_z;
    logic signed [DATA_W-1:0] med_rot_x;
    logic signed [DATA_W-1:0] med_rot_y;
    logic signed [DATA_W-1:0] med_rot_z;
    logic [CNT_W-1:0]         samples_held;
  } result_t;

  localparam int SAMPLE_W = $bits(sample_t);

  // Commands from the sequencer to the rank unit.
  typedef struct packed {
    logic clear;
    logic load;
  } rank_cmd_t;

endpackage

### hdl/swm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; holds the ring of pose samples for the median selector.
`timescale 1ns / 1ps

module swm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/swm_rank.sv
// Rank unit: collects the keys of the window, oldest first, and keeps the
// rank of every key up to date as each new key arrives. Uses swm_pkg.
`timescale 1ns / 1ps

module swm_rank (
  input  logic                            clk,
  input  logic                            rst_n,
  input  swm_pkg::rank_cmd_t              cmd,
  input  logic signed [swm_pkg::DATA_W-1:0] load_key,
  input  logic [swm_pkg::SLOT_W-1:0]      target,
  output logic [swm_pkg::SLOT_W-1:0]      pick_age
);
  import swm_pkg::*;

  logic signed [DATA_W-1:0] key_r    [WINDOW_MAX];
  logic signed [DATA_W-1:0] key_nxt  [WINDOW_MAX];
  logic [SLOT_W-1:0]        rank_r   [WINDOW_MAX];
  logic [SLOT_W-1:0]        rank_nxt [WINDOW_MAX];
  logic [CNT_W-1:0]         ld_cnt_r;
  logic [CNT_W-1:0]         ld_cnt_nxt;
  logic [WINDOW_MAX-1:0]    le_mask;
  logic [SLOT_W-1:0]        new_rank;

  // An older key that is less than or equal to the new one ranks below it;
  // an older key that is strictly greater moves up by one.
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      le_mask[i] = (CNT_W'(i) < ld_cnt_r) && (key_r[i] <= load_key);
    end
    new_rank = SLOT_W'($countones(le_mask));
  end

  always_comb begin
    ld_cnt_nxt = ld_cnt_r;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      key_nxt[i]  = key_r[i];
      rank_nxt[i] = rank_r[i];
    end
    if (cmd.clear) begin
      ld_cnt_nxt = '0;
    end else if (cmd.load) begin
      ld_cnt_nxt = ld_cnt_r + CNT_W'(1);
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (CNT_W'(i) < ld_cnt_r) begin
          if (load_key < key_r[i]) begin
            rank_nxt[i] = rank_r[i] + SLOT_W'(1);
          end
        end else if (CNT_W'(i) == ld_cnt_r) begin
          key_nxt[i]  = load_key;
          rank_nxt[i] = new_rank;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_cnt_r <= '0;
    end else begin
      ld_cnt_r <= ld_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      key_r[i]  <= key_nxt[i];
      rank_r[i] <= rank_nxt[i];
    end
  end

  // Ranks of the loaded lanes are distinct, so at most one lane matches.
  always_comb begin
    pick_age = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if ((CNT_W'(i) < ld_cnt_r) && (rank_r[i] == target)) begin
        pick_age = SLOT_W'(i);
      end
    end
  end

endmodule

### hdl/sliding_window_median_pose.sv
// Sliding-window median selector for pose samples: top level.
// Depends on swm_pkg, swm_ram and swm_rank.
`timescale 1ns / 1ps

// Each accepted item is one pose sample (translation and rotation vector,
// signed Q8.24). The block keeps the most recent window_size samples in a
// ring held in one RAM and, for every item, returns the whole stored sample
// whose rot_x ranks at position count/2 in ascending signed order (the upper
// median for an even count), with older samples ranking first on equal keys,
// together with the number of samples now held. Each item runs through these
// steps in order: the sample is written into the RAM, the keys of the window
// are read back one per cycle through the single read port into the rank
// unit, a drain step covers the read latency, the chosen entry is read and
// the output register is loaded once it is free. The block handles one item
// at a time; the output register lets the next item be accepted while a
// result still waits to be taken. A window_size of zero acts as one and a
// value above sixteen acts as sixteen. Shrinking the window without a reset
// keeps the current count, dropping one oldest sample per item, so reset the
// block after changing window_size. The RAM needs no clearing after reset,
// since only entries that have been written are ever read.

module sliding_window_median_pose (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  swm_pkg::sample_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output swm_pkg::result_t            out_data,
  input  logic                        cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]   cfg_data
);
  import swm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_LAST = 5'b00100,
    S_PICK = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  win_size_r;
  logic [CNT_W-1:0]  eff_win;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SLOT_W-1:0] rd_age_r, rd_age_nxt;
  logic              load_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_data_r;
  logic              in_accept;
  logic              out_load;

  // RAM and rank unit connections.
  logic              ram_wr_en;
  logic [SLOT_W-1:0] ram_wr_addr;
  logic              ram_rd_en;
  logic [SLOT_W-1:0] ram_rd_addr;
  sample_t           ram_rd_data;
  rank_cmd_t         rank_cmd;
  logic [SLOT_W-1:0] pick_age;
  logic [SLOT_W-1:0] target;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // Clamp the configured size into the range the ring supports.
  always_comb begin
    if (win_size_r == '0) begin
      eff_win = CNT_W'(1);
    end else if (CNT_W'(win_size_r) > CNT_W'(WINDOW_MAX)) begin
      eff_win = CNT_W'(WINDOW_MAX);
    end else begin
      eff_win = CNT_W'(win_size_r);
    end
  end

  // The new sample goes in the ring slot just behind the youngest one; once
  // all sixteen slots are in use this is the slot of the oldest sample, which
  // it overwrites.
  assign ram_wr_en   = in_accept;
  assign ram_wr_addr = oldest_r + fill_r[SLOT_W-1:0];

  // The target rank is half the count, rounded down.
  assign target = fill_r[CNT_W-1:1];

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    rd_age_nxt    = rd_age_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = oldest_r + rd_age_r;
    rank_cmd      = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (fill_r >= eff_win) begin
            oldest_nxt = oldest_r + SLOT_W'(1);
          end else begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          rd_age_nxt     = '0;
          rank_cmd.clear = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // Read the keys back from the oldest sample to the youngest.
        ram_rd_en  = 1'b1;
        rd_age_nxt = rd_age_r + SLOT_W'(1);
        if (CNT_W'(rd_age_r) == fill_r - CNT_W'(1)) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        // Ranks are complete; fetch the whole sample at the target rank.
        ram_rd_en   = 1'b1;
        ram_rd_addr = oldest_r + pick_age;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // Hold the read data until the output register is free.
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    rank_cmd.load = load_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_size_r  <= CFG_W'(1);
      fill_r      <= '0;
      oldest_r    <= '0;
      rd_age_r    <= '0;
      load_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      rd_age_r    <= rd_age_nxt;
      load_r      <= (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        win_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.med_trans_x  <= ram_rd_data.trans_x;
      out_data_r.med_trans_y  <= ram_rd_data.trans_y;
      out_data_r.med_trans_z  <= ram_rd_data.trans_z;
      out_data_r.med_rot_x    <= ram_rd_data.rot_x;
      out_data_r.med_rot_y    <= ram_rd_data.rot_y;
      out_data_r.med_rot_z    <= ram_rd_data.rot_z;
      out_data_r.samples_held <= fill_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  swm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  swm_rank u_rank (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (rank_cmd),
    .load_key (ram_rd_data.rot_x),
    .target   (target),
    .pick_age (pick_age)
  );

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register is not one-hot");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_SCAN && fill_r != '0)
    else $error("accepted item did not start a scan of a non-empty window");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_MAX))
    else $error("fill count exceeds the ring depth");

  a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output state");

  a_pending_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result changed before it was taken");
`endif

endmodule
